>>> rtl/core/utf8s_pkg.sv
// ----------------------------------------------------------------------------
// utf8s_pkg: shared types and constants of the UTF-8 sanitizer
// Byte classes, queue item, output item, back-end states and the code point
// limits used to check multi-byte sequences.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8s_pkg;

  // Byte buffer of the back end: up to three held bytes plus one new byte
  localparam int unsigned BufDepth = 4;
  localparam int unsigned BufIdxW  = 2;

  // Queue between front and back, power-of-two depth so pointers wrap
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  // Code point width and limits
  localparam int unsigned CpW = 21;
  localparam logic [CpW-1:0] MaxCodePoint = 21'h10_FFFF;
  localparam logic [CpW-1:0] SurrLo       = 21'h00_D800;
  localparam logic [CpW-1:0] SurrHi       = 21'h00_DFFF;
  localparam logic [CpW-1:0] Min2         = 21'h00_0080;
  localparam logic [CpW-1:0] Min3         = 21'h00_0800;
  localparam logic [CpW-1:0] Min4         = 21'h01_0000;

  // Replacement character U+FFFD
  localparam logic [7:0] Repl0 = 8'hEF;
  localparam logic [7:0] Repl1 = 8'hBF;
  localparam logic [7:0] Repl2 = 8'hBD;

  // Bytes that never appear in well-formed output
  localparam logic [7:0] OverlongC0   = 8'hC0;
  localparam logic [7:0] OverlongC1   = 8'hC1;
  localparam logic [7:0] FirstBadLead = 8'hF5;

  // Byte class; the encoding equals the sequence length, zero when it cannot lead
  typedef enum logic [2:0] {
    CLS_BAD   = 3'd0,
    CLS_ASCII = 3'd1,
    CLS_LEAD2 = 3'd2,
    CLS_LEAD3 = 3'd3,
    CLS_LEAD4 = 3'd4
  } byte_cls_e;

  // Item in the queue between front and back
  typedef struct packed {
    logic [7:0] data;
    byte_cls_e  cls;
    logic       eot;
  } qitem_t;

  // One byte of the back-end buffer
  typedef struct packed {
    logic [7:0] data;
    byte_cls_e  cls;
  } held_t;

  // Output item
  typedef struct packed {
    logic [7:0] clean_byte;
    logic       run_last;
    logic       text_last;
  } out_item_t;

  // Back-end sequencer states
  typedef enum logic [0:0] {
    ST_DECIDE = 1'b0,
    ST_EMIT   = 1'b1
  } back_state_e;

endpackage

`default_nettype wire

>>> rtl/core/utf8s_in_if.sv
// ----------------------------------------------------------------------------
// utf8s_in_if: raw byte channel
// Valid/ready channel carrying one text byte and its end-of-text flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

>>> rtl/core/utf8s_out_if.sv
// ----------------------------------------------------------------------------
// utf8s_out_if: sanitized byte channel
// Valid/ready channel carrying one output byte and its last flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8s_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] clean_byte;
  logic       run_last;
  logic       text_last;

  modport source (output valid, output clean_byte, output run_last, output text_last,
                  input ready);
  modport sink   (input valid, input clean_byte, input run_last, input text_last,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/utf8s_front.sv
// ----------------------------------------------------------------------------
// utf8s_front: input stage and byte classifier
// Registers each incoming item together with its UTF-8 byte class.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8s_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_data_i,
  input  logic              in_eot_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output utf8s_pkg::qitem_t q_item_o
);
  import utf8s_pkg::*;

  logic      valid_q, valid_d;
  qitem_t    item_q;
  byte_cls_e cls_w;
  logic      take;

  // Byte class from the leading bit pattern
  always_comb begin
    if (in_data_i[7] == 1'b0) begin
      cls_w = CLS_ASCII;
    end else if (in_data_i[7:5] == 3'b110) begin
      cls_w = CLS_LEAD2;
    end else if (in_data_i[7:4] == 4'b1110) begin
      cls_w = CLS_LEAD3;
    end else if (in_data_i[7:3] == 5'b11110) begin
      cls_w = CLS_LEAD4;
    end else begin
      cls_w = CLS_BAD;
    end
  end

  // Single register stage; refills as the queue takes
  assign in_ready_o = !valid_q || q_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (q_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= '{data: in_data_i, cls: cls_w, eot: in_eot_i};
    end
  end

  assign q_valid_o = valid_q;
  assign q_item_o  = item_q;

endmodule

`default_nettype wire

>>> rtl/core/utf8s_queue.sv
// ----------------------------------------------------------------------------
// utf8s_queue: classified item queue
// Short FIFO that decouples the classifier from the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8s_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  utf8s_pkg::qitem_t wr_item_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output utf8s_pkg::qitem_t rd_item_o
);
  import utf8s_pkg::*;

  qitem_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 push, pop;

  assign wr_ready_o = (cnt_q != QueueCntW'(QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_item_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q + (push ? QueuePtrW'(1) : '0);
    rd_ptr_d = rd_ptr_q + (pop ? QueuePtrW'(1) : '0);
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QueueCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/utf8s_back.sv
// ----------------------------------------------------------------------------
// utf8s_back: sequence checker and output sequencer
// Holds pending bytes, decides one sequence at the buffer head per step and
// streams the passed bytes or the replacement character into the output
// register, one byte a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8s_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  utf8s_pkg::qitem_t    q_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output utf8s_pkg::out_item_t out_item_o
);
  import utf8s_pkg::*;

  // State
  back_state_e state_q, state_d;
  held_t       hold_q [BufDepth];
  held_t       hold_d [BufDepth];
  logic [2:0]  cnt_q, cnt_d;
  logic        active_q, active_d;
  logic        eot_q, eot_d;
  logic [7:0]  grp_q [BufDepth];
  logic [7:0]  grp_d [BufDepth];
  logic [2:0]  glen_q, glen_d;
  logic [BufIdxW-1:0] idx_q, idx_d;
  logic        glast_q, glast_d;
  out_item_t   out_q, out_d;
  logic        ovalid_q, ovalid_d;

  // Buffer view for this decision
  held_t       view [BufDepth];
  held_t       sview [BufDepth];
  logic [2:0]  vcnt;
  logic        veot;

  // Decision
  logic [2:0]     hlen;
  logic [CpW-1:0] cp;
  logic [CpW-1:0] cp_min;
  logic           cont_ok, range_ok;
  logic           wait_w, repl;
  logic [2:0]     glen, shift;
  logic [7:0]     gbytes [BufDepth];
  logic [2:0]     rem, nlen;
  logic           last;
  logic [2:0]     sidx;

  logic out_free, go, grp_end, emit;

  assign out_free  = !ovalid_q || out_ready_i;
  assign go        = (state_q == ST_DECIDE) && out_free && (active_q || q_valid_i);
  assign q_ready_o = (state_q == ST_DECIDE) && out_free && !active_q;
  assign grp_end   = ({1'b0, idx_q} == (glen_q - 3'd1));

  // Held bytes plus the queue head when a new step starts
  always_comb begin
    view = hold_q;
    vcnt = cnt_q;
    veot = eot_q;
    if (!active_q) begin
      view[cnt_q[BufIdxW-1:0]].data = q_item_i.data;
      view[cnt_q[BufIdxW-1:0]].cls  = q_item_i.cls;
      vcnt = cnt_q + 3'd1;
      veot = q_item_i.eot;
    end
  end

  // Code point and continuation check of the head sequence
  always_comb begin
    unique case (view[0].cls)
      CLS_LEAD2: begin
        cp      = {10'd0, view[0].data[4:0], view[1].data[5:0]};
        cont_ok = (view[1].data[7:6] == 2'b10);
        cp_min  = Min2;
      end
      CLS_LEAD3: begin
        cp      = {5'd0, view[0].data[3:0], view[1].data[5:0], view[2].data[5:0]};
        cont_ok = (view[1].data[7:6] == 2'b10) && (view[2].data[7:6] == 2'b10);
        cp_min  = Min3;
      end
      default: begin
        cp      = {view[0].data[2:0], view[1].data[5:0], view[2].data[5:0],
                   view[3].data[5:0]};
        cont_ok = (view[1].data[7:6] == 2'b10) && (view[2].data[7:6] == 2'b10) &&
                  (view[3].data[7:6] == 2'b10);
        cp_min  = Min4;
      end
    endcase
    range_ok = (cp >= cp_min) && (cp <= MaxCodePoint) &&
               !((cp >= SurrLo) && (cp <= SurrHi));
  end

  // Head decision: pass, replace or wait for more bytes
  always_comb begin
    hlen   = view[0].cls;
    wait_w = 1'b0;
    repl   = 1'b0;
    glen   = 3'd1;
    shift  = 3'd1;
    case (view[0].cls) inside
      CLS_ASCII: begin
        repl = 1'b0;
      end
      CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
        if (vcnt < hlen) begin
          if (veot) begin
            repl = 1'b1;
          end else begin
            wait_w = 1'b1;
          end
        end else if (cont_ok && range_ok) begin
          glen  = hlen;
          shift = hlen;
        end else begin
          repl = 1'b1;
        end
      end
      default: begin
        repl = 1'b1;
      end
    endcase

    for (int j = 0; j < BufDepth; j++) begin
      gbytes[j] = view[j].data;
    end
    if (repl) begin
      gbytes[0] = Repl0;
      gbytes[1] = Repl1;
      gbytes[2] = Repl2;
      glen      = 3'd3;
    end

    // Remaining bytes after this group; the group ends the step when they
    // are gone or the next lead must wait
    rem  = vcnt - shift;
    nlen = view[shift[BufIdxW-1:0]].cls;
    last = (rem == 3'd0) || (!veot && (nlen >= 3'd2) && (rem < nlen));

    for (int j = 0; j < BufDepth; j++) begin
      sidx     = 3'(j) + shift;
      sview[j] = view[sidx[BufIdxW-1:0]];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_DECIDE: begin
        if (go && !wait_w && (glen != 3'd1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && grp_end) begin
          state_d = ST_DECIDE;
        end
      end
      default: begin
        state_d = ST_DECIDE;
      end
    endcase
  end

  // Buffer, group and output register updates
  always_comb begin
    hold_d   = hold_q;
    cnt_d    = cnt_q;
    active_d = active_q;
    eot_d    = eot_q;
    grp_d    = grp_q;
    glen_d   = glen_q;
    idx_d    = idx_q;
    glast_d  = glast_q;
    out_d    = out_q;
    emit     = 1'b0;
    unique case (state_q)
      ST_DECIDE: begin
        if (go) begin
          if (wait_w) begin
            hold_d   = view;
            cnt_d    = vcnt;
            active_d = 1'b0;
          end else begin
            emit             = 1'b1;
            out_d.clean_byte = gbytes[0];
            out_d.run_last   = last && (glen == 3'd1);
            out_d.text_last  = last && (glen == 3'd1) && veot;
            hold_d           = sview;
            cnt_d            = rem;
            eot_d            = veot;
            active_d         = !last;
            grp_d            = gbytes;
            glen_d           = glen;
            idx_d            = BufIdxW'(1);
            glast_d          = last;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit             = 1'b1;
          out_d.clean_byte = grp_q[idx_q];
          out_d.run_last   = glast_q && grp_end;
          out_d.text_last  = glast_q && grp_end && eot_q;
          idx_d            = idx_q + BufIdxW'(1);
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    ovalid_d = ovalid_q;
    if (emit) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_DECIDE;
      cnt_q    <= 3'd0;
      active_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      active_q <= active_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q  <= hold_d;
    eot_q   <= eot_d;
    grp_q   <= grp_d;
    glen_q  <= glen_d;
    idx_q   <= idx_d;
    glast_q <= glast_d;
    out_q   <= out_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/core/utf8_sanitizer.sv
// ----------------------------------------------------------------------------
// utf8_sanitizer: streaming UTF-8 validator with replacement
// Passes well-formed UTF-8 unchanged and puts EF BF BD in place of each bad
// lead byte, re-examining the bytes after it.
// ----------------------------------------------------------------------------
// A byte enters through a register stage that classifies it and a two-item
// queue, so input keeps flowing while the output sequencer works. The
// sequencer writes one output byte per cycle while its output is not
// stalled: an item causes one result byte for ASCII, three per replaced
// lead, the whole sequence on its final byte, up to twelve, and none when
// it only completes part of a sequence. run_last marks the last byte caused
// by an input byte; text_last marks the final byte of the text, after which
// nothing is held. The first output byte caused by an item passes the
// classifier register, the queue and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_sanitizer (
  input  logic               clk_i,
  input  logic               rst_ni,
  utf8s_in_if.sink           in_i,
  utf8s_out_if.source        out_o
);
  import utf8s_pkg::*;

  logic      fq_valid, fq_ready;
  qitem_t    fq_item;
  logic      qb_valid, qb_ready;
  qitem_t    qb_item;
  logic      out_valid;
  out_item_t out_item;

  utf8s_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_data_i  (in_i.data_byte),
    .in_eot_i   (in_i.end_of_text),
    .q_valid_o  (fq_valid),
    .q_ready_i  (fq_ready),
    .q_item_o   (fq_item)
  );

  utf8s_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_item_i  (fq_item),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_item_o  (qb_item)
  );

  utf8s_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (qb_valid),
    .q_ready_o   (qb_ready),
    .q_item_i    (qb_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_item)
  );

  assign out_o.valid      = out_valid;
  assign out_o.clean_byte = out_item.clean_byte;
  assign out_o.run_last   = out_item.run_last;
  assign out_o.text_last  = out_item.text_last;

endmodule

`default_nettype wire

>>> rtl/core/utf8s_checker.sv
// ----------------------------------------------------------------------------
// utf8s_checker: output checks of the UTF-8 sanitizer
// Watches the output channel for handshake hold and well-formed output.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8s_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] clean_byte_i,
  input logic       run_last_i,
  input logic       text_last_i
);
  import utf8s_pkg::*;

  // A stalled output item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(clean_byte_i) &&
    $stable(run_last_i) && $stable(text_last_i))
    else $error("stalled output item changed");

  // End of text only closes a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && text_last_i |-> run_last_i)
    else $error("text_last without run_last");

  // EF always starts a three-byte group, never ends a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (clean_byte_i == Repl0) |-> !run_last_i)
    else $error("run ends on EF");

  // Bytes that cannot occur in well-formed UTF-8 never leave
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !((clean_byte_i == OverlongC0) || (clean_byte_i == OverlongC1) ||
                      (clean_byte_i >= FirstBadLead)))
    else $error("ill-formed byte on output");

endmodule

bind utf8_sanitizer utf8s_checker u_utf8s_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .clean_byte_i (out_o.clean_byte),
  .run_last_i   (out_o.run_last),
  .text_last_i  (out_o.text_last)
);

`default_nettype wire

>>> tb/utf8_sanitizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_sanitizer_tb: self-checking regression of the UTF-8 sanitizer
// Directed byte sequences cover ASCII, every sequence length, bad leads, bad
// continuations, overlong forms, surrogates, values above range and
// truncation at end of text. A long random text follows, mostly well-formed
// code points with broken sequences and noise mixed in. A behavioral model of
// the sanitizer predicts every output item. The sender works in bursts with
// idle gaps between them and the receiver stalls on changing patterns.
// ----------------------------------------------------------------------------

module utf8_sanitizer_tb;
  import utf8s_pkg::*;

  localparam int DrainCycles  = 8;          // margin after the predictions drain
  localparam int RandomItems  = 385;
  localparam int PauseEvery   = 100;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_FULL     = 2'd0,
    RX_RANDOM   = 2'd1,
    RX_PERIODIC = 2'd2,
    RX_BURSTY   = 2'd3
  } rx_mode_e;

  logic clk_i;
  logic rst_ni;

  utf8s_in_if  in_if ();
  utf8s_out_if out_if ();

  utf8_sanitizer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Model state: bytes held back while a sequence is incomplete
  logic [7:0] hold_bytes [3];
  int         hold_cnt = 0;

  out_item_t  clean_q [$];     // predicted output items, oldest first
  logic [7:0] step_bytes [$];  // output bytes of the item being predicted
  logic [7:0] seq_q [$];       // byte sequence to send next

  int errors = 0;
  int items_sent;
  int burst_left;

  rx_mode_e rx_mode  = RX_FULL;
  int       rx_cycle = 0;
  int       rx_run   = 0;
  logic     rx_level = 1'b0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("utf8_sanitizer regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sanitizer model
  // ---------------------------------------------------------------------------

  function automatic byte_cls_e lead_class(input logic [7:0] b);
    if (!b[7])                 return CLS_ASCII;
    if (b[7:5] == 3'b110)      return CLS_LEAD2;
    if (b[7:4] == 4'b1110)     return CLS_LEAD3;
    if (b[7:3] == 5'b11110)    return CLS_LEAD4;
    return CLS_BAD;
  endfunction

  function automatic void add_replacement();
    step_bytes.insert(step_bytes.size(), Repl0);
    step_bytes.insert(step_bytes.size(), Repl1);
    step_bytes.insert(step_bytes.size(), Repl2);
  endfunction

  // Decide as much of the held bytes plus the new byte as possible
  function automatic void sanitize_byte(input logic [7:0] din, input logic end_txt);
    logic [7:0]     win [4];
    logic [CpW-1:0] cp;
    logic [CpW-1:0] floor_cp;
    byte_cls_e      cls;
    out_item_t      item;
    int             n;
    int             i;
    int             k;
    int             len;
    bit             ok;
    bit             waiting;

    step_bytes.delete();
    n       = 0;
    i       = 0;
    waiting = 1'b0;
    for (k = 0; k < hold_cnt; k++) begin
      win[n] = hold_bytes[k];
      n++;
    end
    win[n] = din;
    n++;

    while (i < n && !waiting) begin
      cls = lead_class(win[i]);
      len = int'(cls);
      if (cls == CLS_ASCII) begin
        step_bytes.insert(step_bytes.size(), win[i]);
        i++;
      end else if (cls == CLS_BAD) begin
        add_replacement();
        i++;
      end else if (n - i < len) begin
        // incomplete: replaced at end of text, held otherwise
        if (end_txt) begin
          add_replacement();
          i++;
        end else begin
          waiting = 1'b1;
        end
      end else begin
        case (cls)
          CLS_LEAD2: begin
            cp       = {16'd0, win[i][4:0]};
            floor_cp = Min2;
          end
          CLS_LEAD3: begin
            cp       = {17'd0, win[i][3:0]};
            floor_cp = Min3;
          end
          default: begin
            cp       = {18'd0, win[i][2:0]};
            floor_cp = Min4;
          end
        endcase
        ok = 1'b1;
        for (k = 1; k < len; k++) begin
          if (win[i+k][7:6] != 2'b10) ok = 1'b0;
          cp = {cp[CpW-7:0], win[i+k][5:0]};
        end
        // overlong, above range and surrogate checks
        if (ok) ok = (cp >= floor_cp) && (cp <= MaxCodePoint) &&
                     !(cp >= SurrLo && cp <= SurrHi);
        if (ok) begin
          for (k = 0; k < len; k++) step_bytes.insert(step_bytes.size(), win[i+k]);
          i += len;
        end else begin
          add_replacement();
          i++;
        end
      end
    end

    hold_cnt = n - i;
    for (k = 0; k < hold_cnt; k++) hold_bytes[k] = win[i+k];

    for (k = 0; k < step_bytes.size(); k++) begin
      item.clean_byte = step_bytes[k];
      item.run_last   = (k == step_bytes.size() - 1);
      item.text_last  = (k == step_bytes.size() - 1) && end_txt;
      clean_q.insert(clean_q.size(), item);
    end
  endfunction

  // Predict on every accepted input item
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      sanitize_byte(in_if.data_byte, in_if.end_of_text);
    end
  end

  // Compare every accepted output item with the oldest prediction
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (clean_q.size() == 0) begin
        $display("%0t: unexpected output: expected none, actual byte %h run_last %b text_last %b",
                 $time, out_if.clean_byte, out_if.run_last, out_if.text_last);
        errors++;
      end else begin
        want = clean_q[0];
        clean_q.delete(0);
        if (out_if.clean_byte !== want.clean_byte) begin
          $display("%0t: clean_byte mismatch: expected %h actual %h",
                   $time, want.clean_byte, out_if.clean_byte);
          errors++;
        end
        if (out_if.run_last !== want.run_last) begin
          $display("%0t: run_last mismatch: expected %b actual %b",
                   $time, want.run_last, out_if.run_last);
          errors++;
        end
        if (out_if.text_last !== want.text_last) begin
          $display("%0t: text_last mismatch: expected %b actual %b",
                   $time, want.text_last, out_if.text_last);
          errors++;
        end
      end
    end
  end

  // Receiver: the stall pattern is redrawn at random periodically
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_FULL:     out_if.ready <= 1'b1;
      RX_RANDOM:   out_if.ready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: out_if.ready <= (rx_cycle % 5 != 0);
      default: begin
        if (rx_run == 0) begin
          rx_level = ~rx_level;
          rx_run   = $urandom_range(1, 8);
        end
        rx_run--;
        out_if.ready <= rx_level;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one item; valid stays high while a burst goes on
  task automatic send_byte(input logic [7:0] b, input logic end_txt);
    int gap;
    in_if.data_byte   <= b;
    in_if.end_of_text <= end_txt;
    in_if.valid       <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 5);
    end
  endtask

  // Hold off the sender until every predicted item has come out; the first
  // edge lets the prediction of the last accepted item land
  task automatic drain_outputs();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (clean_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_seq(input bit end_last);
    int k;
    for (k = 0; k < seq_q.size(); k++) begin
      send_byte(seq_q[k], end_last && (k == seq_q.size() - 1));
    end
  endtask

  // Encode cp on len bytes; a len longer than cp needs gives an overlong form
  function automatic void load_code_point(input logic [CpW-1:0] cp, input int len);
    seq_q.delete();
    case (len)
      1: seq_q.insert(seq_q.size(), {1'b0, cp[6:0]});
      2: begin
        seq_q.insert(seq_q.size(), {3'b110, cp[10:6]});
        seq_q.insert(seq_q.size(), {2'b10, cp[5:0]});
      end
      3: begin
        seq_q.insert(seq_q.size(), {4'b1110, cp[15:12]});
        seq_q.insert(seq_q.size(), {2'b10, cp[11:6]});
        seq_q.insert(seq_q.size(), {2'b10, cp[5:0]});
      end
      default: begin
        seq_q.insert(seq_q.size(), {5'b11110, cp[20:18]});
        seq_q.insert(seq_q.size(), {2'b10, cp[17:12]});
        seq_q.insert(seq_q.size(), {2'b10, cp[11:6]});
        seq_q.insert(seq_q.size(), {2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic logic [CpW-1:0] pick_code_point(input int len);
    logic [CpW-1:0] cp;
    case (len)
      1: cp = CpW'($urandom_range(0, 'h7F));
      2: cp = CpW'($urandom_range('h80, 'h7FF));
      3: begin
        do cp = CpW'($urandom_range('h800, 'hFFFF));
        while (cp >= SurrLo && cp <= SurrHi);
      end
      default: cp = CpW'($urandom_range('h1_0000, 'h10_FFFF));
    endcase
    return cp;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_ascii();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
  endtask

  task automatic test_well_formed();
    // smallest two-byte, smallest three-byte, largest four-byte
    send_byte(8'hC2, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hE0, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
  endtask

  task automatic test_bad_leads();
    send_byte(8'h80, 1'b0);   // stray continuation
    send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_overlong();
    send_byte(8'hC0, 1'b0);
    send_byte(8'hAF, 1'b0);
  endtask

  task automatic test_surrogate();
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  task automatic test_above_range();
    send_byte(8'hF4, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  task automatic test_bad_continuation();
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
  endtask

  task automatic test_truncation();
    // three-byte lead cut short by end of text
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
  endtask

  // Random text: mostly well-formed, with noise and broken sequences
  task automatic test_random_text(input int count);
    int first;
    int next_pause;
    int r;
    int len;
    int k;
    bit end_last;
    logic [7:0] junk;

    first      = items_sent;
    next_pause = items_sent + PauseEvery;
    while (items_sent - first < count) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        len = $urandom_range(1, 4);
        load_code_point(pick_code_point(len), len);
      end else if (r < 70) begin
        seq_q.delete();
        seq_q.insert(0, 8'($urandom_range(0, 255)));
      end else if (r < 80) begin
        // truncated sequence, the next one starts early
        len = $urandom_range(2, 4);
        load_code_point(pick_code_point(len), len);
        k = $urandom_range(1, len - 1);
        while (seq_q.size() > k) seq_q.delete(seq_q.size() - 1);
      end else if (r < 88) begin
        // one continuation replaced by a byte that cannot continue
        len = $urandom_range(2, 4);
        load_code_point(pick_code_point(len), len);
        k = $urandom_range(1, len - 1);
        do junk = 8'($urandom_range(0, 255)); while (junk[7:6] == 2'b10);
        seq_q[k] = junk;
      end else if (r < 94) begin
        len = $urandom_range(2, 4);
        case (len)
          2:       load_code_point(CpW'($urandom_range(0, 'h7F)), 2);
          3:       load_code_point(CpW'($urandom_range(0, 'h7FF)), 3);
          default: load_code_point(CpW'($urandom_range(0, 'hFFFF)), 4);
        endcase
      end else if (r < 97) begin
        load_code_point(CpW'($urandom_range(SurrLo, SurrHi)), 3);
      end else begin
        load_code_point(CpW'($urandom_range('h11_0000, 'h1F_FFFF)), 4);
      end

      end_last = ($urandom_range(0, 11) == 0) || (items_sent - first + seq_q.size() >= count);
      send_seq(end_last);

      if (items_sent >= next_pause) begin
        drain_outputs();
        next_pause = items_sent + PauseEvery;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.data_byte   = 8'h00;
    in_if.end_of_text = 1'b0;
    items_sent        = 0;
    burst_left        = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ascii();
    test_well_formed();
    test_bad_leads();
    test_overlong();
    drain_outputs();
    test_surrogate();
    test_above_range();
    test_bad_continuation();
    test_truncation();
    drain_outputs();
    test_random_text(RandomItems);
    drain_outputs();

    if (errors == 0 && clean_q.size() == 0) begin
      $display("utf8_sanitizer regression: pass");
    end else begin
      $display("utf8_sanitizer regression: fail");
    end
    $finish;
  end

endmodule
